>>> sv/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit sequencer package
// Shared types and phase constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

   // Commands, as carried in the action field of a request beat.
   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_RDACK = 3'd3,
      CMD_RDNAK = 3'd4,
      CMD_STOP  = 3'd5
   } cmd_type;

   localparam int PHASE_W = 5;

   // Write command: eight bits of three phases each, then the ack slot.
   localparam logic [PHASE_W-1:0] WR_BITS_END = 5'd24;
   localparam logic [PHASE_W-1:0] WR_ACK_HIGH = 5'd25;

   // Read command: eight bits of two phases each, then the ack slot.
   localparam logic [PHASE_W-1:0] RD_BITS_END = 5'd16;
   localparam logic [PHASE_W-1:0] RD_ACK_HIGH = 5'd17;
   localparam logic [PHASE_W-1:0] RD_ACK_LOW  = 5'd18;

   // Position inside one written bit.
   localparam logic [1:0] WSUB_DATA = 2'd0;
   localparam logic [1:0] WSUB_HIGH = 2'd1;
   localparam logic [1:0] WSUB_LOW  = 2'd2;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic       ack_seen;
      logic [7:0] rx_byte;
   } rsp_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [PHASE_W-1:0]   phase;
      logic [1:0]           wsub;
      logic [7:0]           shift;
      logic                 scl;
      logic                 sda;
   } state_type;

   localparam state_type STATE_RESET = '{
      cmd:   CMD_IDLE,
      phase: '0,
      wsub:  WSUB_DATA,
      shift: '0,
      scl:   1'b1,
      sda:   1'b1
   };

endpackage

>>> sv/i2cbs_phase_step.sv
// ----------------------------------------------------------------------------
// I2C bit sequencer phase step
// Combinational next-state and result logic for one bus phase.
// ----------------------------------------------------------------------------
module i2cbs_phase_step (
   input  i2cbs_pkg::state_type cur_state,
   input  i2cbs_pkg::req_type   req,
   output i2cbs_pkg::state_type nxt_state,
   output i2cbs_pkg::rsp_type   rsp
);

   always_comb begin
      i2cbs_pkg::state_type st;
      logic                 fin;
      logic                 ack_now;

      st      = cur_state;
      fin     = 1'b0;
      ack_now = 1'b0;
      rsp     = '0;

      // A new command is taken only while idle; unknown codes are dropped.
      if (cur_state.cmd == i2cbs_pkg::CMD_IDLE) begin
         case (i2cbs_pkg::cmd_type'(req.action))
            i2cbs_pkg::CMD_START, i2cbs_pkg::CMD_WRITE, i2cbs_pkg::CMD_RDACK,
            i2cbs_pkg::CMD_RDNAK, i2cbs_pkg::CMD_STOP: begin
               st.cmd   = i2cbs_pkg::cmd_type'(req.action);
               st.phase = '0;
               st.wsub  = i2cbs_pkg::WSUB_DATA;
               st.shift = (req.action == i2cbs_pkg::CMD_WRITE) ? req.tx_byte : 8'h00;
            end
            default: begin
            end
         endcase
      end

      case (st.cmd)
         i2cbs_pkg::CMD_START: begin
            if (st.phase == '0) begin
               st.sda = 1'b0;
            end else begin
               st.scl = 1'b0;
               fin    = 1'b1;
            end
         end
         i2cbs_pkg::CMD_WRITE: begin
            if (st.phase < i2cbs_pkg::WR_BITS_END) begin
               case (st.wsub)
                  i2cbs_pkg::WSUB_DATA: st.sda = st.shift[7];
                  i2cbs_pkg::WSUB_HIGH: st.scl = 1'b1;
                  i2cbs_pkg::WSUB_LOW: begin
                     st.scl   = 1'b0;
                     st.shift = {st.shift[6:0], 1'b0};
                  end
                  default: begin
                  end
               endcase
               st.wsub = (st.wsub == i2cbs_pkg::WSUB_LOW) ? i2cbs_pkg::WSUB_DATA
                                                          : st.wsub + 2'd1;
            end else if (st.phase == i2cbs_pkg::WR_BITS_END) begin
               st.sda = 1'b1;
            end else if (st.phase == i2cbs_pkg::WR_ACK_HIGH) begin
               st.scl = 1'b1;
            end else begin
               // The slave acknowledges by pulling the data line low.
               ack_now = ~req.sda_level;
               st.scl  = 1'b0;
               fin     = 1'b1;
            end
         end
         i2cbs_pkg::CMD_RDACK, i2cbs_pkg::CMD_RDNAK: begin
            if (st.phase < i2cbs_pkg::RD_BITS_END) begin
               if (!st.phase[0]) begin
                  st.sda = 1'b1;
                  st.scl = 1'b1;
               end else begin
                  st.shift = {st.shift[6:0], req.sda_level};
                  st.scl   = 1'b0;
               end
            end else if (st.phase == i2cbs_pkg::RD_BITS_END) begin
               st.sda = (st.cmd == i2cbs_pkg::CMD_RDNAK);
            end else if (st.phase == i2cbs_pkg::RD_ACK_HIGH) begin
               st.scl = 1'b1;
            end else if (st.phase == i2cbs_pkg::RD_ACK_LOW) begin
               st.scl = 1'b0;
            end else begin
               st.sda = (st.cmd == i2cbs_pkg::CMD_RDACK);
               fin    = 1'b1;
            end
         end
         i2cbs_pkg::CMD_STOP: begin
            if (st.phase == '0) begin
               st.sda = 1'b0;
            end else if (st.phase == 5'd1) begin
               st.scl = 1'b1;
            end else begin
               st.sda = 1'b1;
               fin    = 1'b1;
            end
         end
         default: begin
            fin = 1'b1;
         end
      endcase

      if (st.cmd != i2cbs_pkg::CMD_IDLE) begin
         if (fin) begin
            rsp.done_res = 1'b1;
            if (st.cmd == i2cbs_pkg::CMD_WRITE) begin
               rsp.ack_seen = ack_now;
            end
            if (st.cmd == i2cbs_pkg::CMD_RDACK || st.cmd == i2cbs_pkg::CMD_RDNAK) begin
               rsp.rx_byte = st.shift;
            end
            st.cmd   = i2cbs_pkg::CMD_IDLE;
            st.phase = '0;
         end else begin
            rsp.busy_res = 1'b1;
            st.phase     = st.phase + 5'd1;
         end
      end

      rsp.scl_level   = st.scl;
      rsp.sda_release = st.sda;
      nxt_state       = st;
   end

endmodule

>>> sv/i2c_master_bit_sequencer_unit.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Advances an I2C master by one bus phase for every request beat.
// ----------------------------------------------------------------------------
// Each request beat is one tick: it may carry a command (start, write byte,
// read with ack, read with nack, stop), which is taken only while no command
// runs, and it carries the sampled data line level. Every request beat yields
// exactly one response beat with the line levels after that tick, busy/done,
// and the ack or received byte on the finishing tick. A new beat is taken in
// every clock cycle unless a response beat is stalled; each beat passes
// through the input register, the single phase step and the result register.
// Commands last 2 (start), 27 (write), 20 (read) and 3 (stop) ticks.
module i2c_master_bit_sequencer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cbs_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cbs_pkg::rsp_type  rsp_data
);

   logic                 s1_valid_ff;
   i2cbs_pkg::req_type   s1_data_ff;
   i2cbs_pkg::state_type state_ff;
   i2cbs_pkg::state_type state_in;
   logic                 rsp_valid_ff;
   i2cbs_pkg::rsp_type   rsp_data_ff;
   i2cbs_pkg::rsp_type   rsp_in;
   logic                 out_adv;
   logic                 step;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_adv;
   assign step      = s1_valid_ff && out_adv;

   i2cbs_phase_step u_step (
      .cur_state (state_ff),
      .req       (s1_data_ff),
      .nxt_state (state_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2cbs_pkg::STATE_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/i2cbs_checker.sv
// ----------------------------------------------------------------------------
// I2C bit sequencer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input i2cbs_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input i2cbs_pkg::rsp_type rsp_data
);

   // An offered request beat holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat changed while waiting");

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.busy_res && rsp_data.done_res))
      else $error("busy and done raised together");

   // The ack and the received byte are only reported on a finishing tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.ack_seen || (rsp_data.rx_byte != 8'h00))
         |-> rsp_data.done_res)
      else $error("ack or received byte reported without done");

endmodule

bind i2c_master_bit_sequencer_unit i2cbs_checker u_i2cbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
